FILE: rtl/frt_pkg.sv
// Package with shared constants, status codes and cell types for the reassembly tracker.
package frt_pkg;

  localparam int MaxFragsDefault = 16;
  localparam logic [15:0] TimeoutReset = 16'd3;

  typedef enum logic [3:0] {
    ST_STARTED   = 4'd0,
    ST_RESTARTED = 4'd1,
    ST_STORED    = 4'd2,
    ST_REDUNDANT = 4'd3,
    ST_COMPLETE  = 4'd4,
    ST_ERROR     = 4'd5,
    ST_FULL      = 4'd6,
    ST_PURGED    = 4'd7,
    ST_IDLE      = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PULL = 2'd1,
    OP_PUSH = 2'd2,
    OP_LOAD = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [15:0] off;
    logic [15:0] size;
  } cell_ctl_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
  } ival_t;

endpackage

FILE: rtl/frt_cell.sv
// One table cell holding a fragment interval, taking a neighbour's interval or loading a new one on command.
module frt_cell
  import frt_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  ival_t     lo_in,
  input  ival_t     hi_in,
  output ival_t     val_out
);

  ival_t val_r;
  ival_t val_nxt;

  always_comb begin
    unique case (ctl.op)
      OP_HOLD: val_nxt = val_r;
      OP_PULL: val_nxt = hi_in;
      OP_PUSH: val_nxt = lo_in;
      OP_LOAD: val_nxt = '{start: ctl.off, size: ctl.size};
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_out = val_r;

endmodule

FILE: rtl/fragment_reassembly_tracker.sv
// Top level of the fragment reassembly tracker: control sequencer and the cell row.
// A purge tick goes straight to the result beat; a start or restart loads cell 0 alone.
// A redundant or full fragment is found by one rotation of the row to locate it; an
// inserted fragment also drops the held intervals it replaces and rotates the row once
// more to walk coverage. The tracker takes no new item until the result beat of the last
// one is loaded, and the next one can be taken in the cycle after that. Reset (rst_n low,
// synchronous) clears the context, the interval count, the timer and the result beat,
// and sets the timeout back to 3.
module fragment_reassembly_tracker
  import frt_pkg::*;
#(
  parameter int MAX_FRAGS = MaxFragsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_msg_id,
  input  logic [15:0] in_frag_offset,
  input  logic [15:0] in_payload_size,
  input  logic [15:0] in_total_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_message_len,
  output logic [4:0]  out_entries_held,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);

  localparam int CW = $clog2(MAX_FRAGS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DEC, S_DEL, S_PUT, S_COV, S_FIN, S_OUT
  } state_t;

  state_t        state_r;
  logic [15:0]   timeout_r;
  logic          ctx_valid_r;
  logic [31:0]   ctx_id_r;
  logic [15:0]   total_r;
  logic [15:0]   ticks_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] b_r;
  logic [CW-1:0] a_r;
  logic [CW-1:0] del_r;
  logic          found_a_r;
  logic [16:0]   prev_end_r;
  logic [15:0]   start_a_r;
  logic [16:0]   end_r;
  logic [15:0]   off_r;
  logic [15:0]   size_r;
  logic [15:0]   tot_r;
  logic          push_r;
  logic          restart_r;
  logic [16:0]   cov_r;
  logic          cov_run_r;
  logic          cov_err_r;
  status_t       st_r;
  logic [15:0]   mlen_r;
  status_t       out_status_r;
  logic [15:0]   out_mlen_r;
  logic [4:0]    out_held_r;
  logic          ovalid_r;

  ival_t         cv [MAX_FRAGS];
  ival_t         head;
  logic [16:0]   head_end;
  logic          pos_valid;
  logic          acc;
  logic          restart_hit;
  logic [CW-1:0] span;
  logic [CW:0]   newcount;

  assign head      = cv[0];
  assign head_end  = {1'b0, head.start} + {1'b0, head.size};
  assign pos_valid = pos_r < count_r;
  assign span      = a_r - b_r;
  assign newcount  = {1'b0, count_r} - {1'b0, span} + (CW+1)'(1);

  assign acc         = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign cfg_ready   = (state_r == S_IDLE) && !in_valid && !ovalid_r;
  assign restart_hit = !ctx_valid_r || in_msg_id != ctx_id_r ||
                       (count_r != '0 && in_total_len != total_r) ||
                       in_payload_size == '0;

  for (genvar g = 0; g < MAX_FRAGS; g++) begin : g_row
    ival_t     lo_nb;
    ival_t     hi_nb;
    cell_ctl_t ctl;
    if (g == 0) begin : g_head
      assign lo_nb = '0;
    end else begin : g_body
      assign lo_nb = cv[g-1];
    end
    if (g == MAX_FRAGS - 1) begin : g_tail
      assign hi_nb = cv[0];
    end else begin : g_mid
      assign hi_nb = cv[g+1];
    end
    always_comb begin
      ctl.off  = off_r;
      ctl.size = size_r;
      unique case (state_r)
        S_SCAN, S_COV: ctl.op = OP_PULL;
        S_DEL: ctl.op = (CW'(g) >= b_r) ? OP_PULL : OP_HOLD;
        S_PUT: begin
          if (CW'(g) == b_r) ctl.op = OP_LOAD;
          else if (push_r && CW'(g) > b_r) ctl.op = OP_PUSH;
          else ctl.op = OP_HOLD;
        end
        default: ctl.op = OP_HOLD;
      endcase
    end
    frt_cell u_cell (
      .clk(clk), .ctl(ctl), .lo_in(lo_nb), .hi_in(hi_nb), .val_out(cv[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TimeoutReset;
      ctx_valid_r <= 1'b0;
      ctx_id_r    <= '0;
      total_r     <= '0;
      ticks_r     <= '0;
      count_r     <= '0;
      ovalid_r    <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_r <= cfg_timeout_ticks;
      if (state_r == S_OUT && (!ovalid_r || !out_stall)) begin
        ovalid_r     <= 1'b1;
        out_status_r <= st_r;
        out_mlen_r   <= mlen_r;
        out_held_r   <= 5'(count_r);
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            mlen_r     <= '0;
            off_r      <= in_frag_offset;
            size_r     <= in_payload_size;
            tot_r      <= in_total_len;
            end_r      <= {1'b0, in_frag_offset} + {1'b0, in_payload_size};
            pos_r      <= '0;
            b_r        <= '0;
            a_r        <= '0;
            found_a_r  <= 1'b0;
            prev_end_r <= '0;
            start_a_r  <= '0;
            push_r     <= 1'b0;
            restart_r  <= restart_hit;
            if (in_func) begin
              if (!ctx_valid_r) begin
                st_r <= ST_IDLE;
              end else if (ticks_r == '0) begin
                ctx_valid_r <= 1'b0;
                count_r     <= '0;
                st_r        <= ST_PURGED;
              end else begin
                ticks_r <= ticks_r - 16'd1;
                st_r    <= ST_IDLE;
              end
              state_r <= S_OUT;
            end else if (restart_hit) begin
              st_r <= ctx_valid_r ? ST_RESTARTED : ST_STARTED;
              if (!ctx_valid_r) ticks_r <= timeout_r;
              ctx_valid_r <= 1'b1;
              ctx_id_r    <= in_msg_id;
              total_r     <= in_total_len;
              state_r     <= S_PUT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pos_valid) begin
            if (head.start < off_r) begin
              b_r        <= b_r + CW'(1);
              a_r        <= a_r + CW'(1);
              prev_end_r <= head_end;
            end else if ({1'b0, head.start} < end_r) begin
              a_r <= a_r + CW'(1);
            end else if (!found_a_r) begin
              found_a_r <= 1'b1;
              start_a_r <= head.start;
            end
          end
          if (pos_r == CW'(MAX_FRAGS - 1)) begin
            pos_r   <= '0;
            state_r <= S_DEC;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        S_DEC: begin
          if (b_r != '0 && found_a_r && prev_end_r >= {1'b0, start_a_r}) begin
            st_r    <= ST_REDUNDANT;
            state_r <= S_OUT;
          end else if (newcount > (CW+1)'(MAX_FRAGS)) begin
            st_r    <= ST_FULL;
            state_r <= S_OUT;
          end else begin
            if (count_r == '0) total_r <= tot_r;
            ticks_r <= timeout_r;
            push_r  <= (span == '0);
            del_r   <= span - CW'(1);
            state_r <= (span > CW'(1)) ? S_DEL : S_PUT;
          end
        end
        S_DEL: begin
          del_r <= del_r - CW'(1);
          if (del_r == CW'(1)) state_r <= S_PUT;
        end
        S_PUT: begin
          if (restart_r) begin
            count_r <= CW'(1);
            state_r <= S_OUT;
          end else begin
            count_r   <= newcount[CW-1:0];
            pos_r     <= '0;
            cov_r     <= '0;
            cov_run_r <= 1'b1;
            cov_err_r <= 1'b0;
            state_r   <= S_COV;
          end
        end
        S_COV: begin
          if (cov_run_r && pos_valid) begin
            if ({1'b0, head.start} <= cov_r) begin
              if (head.size == '0 || head_end <= cov_r) begin
                cov_err_r <= 1'b1;
                cov_run_r <= 1'b0;
              end else begin
                cov_r <= head_end;
              end
            end else begin
              cov_run_r <= 1'b0;
            end
          end
          if (pos_r == CW'(MAX_FRAGS - 1)) begin
            pos_r   <= '0;
            state_r <= S_FIN;
          end else begin
            pos_r <= pos_r + CW'(1);
          end
        end
        S_FIN: begin
          if (total_r == '0 || cov_err_r) begin
            st_r    <= ST_ERROR;
            count_r <= '0;
            ticks_r <= '0;
          end else if (cov_r >= {1'b0, total_r}) begin
            st_r    <= ST_COMPLETE;
            mlen_r  <= total_r;
            count_r <= '0;
            ticks_r <= '0;
          end else begin
            st_r <= ST_STORED;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = ovalid_r;
  assign out_status       = out_status_r;
  assign out_message_len  = out_mlen_r;
  assign out_entries_held = out_held_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_message_len) && $stable(out_entries_held));

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_FRAGS));

  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall && !out_valid);

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_IDLE);

endmodule
